FILE: sv/scht_pkg.sv
// Shared types, constants and helpers for the segment/capsule hit test.
package scht_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 12;
    localparam int SP_BITS    = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int RADIUS_W   = 23;
    localparam int DIST_W     = 48;
    localparam int DIST_LSB   = 2 * SP_BITS;

    // Datapath width: holds products of two dot products and the distance sum.
    localparam int WIDE_A     = 4 * COORD_BITS + 8;
    localparam int WIDE_B     = 2 * COORD_BITS + 54;
    localparam int WIDE_AB    = (WIDE_A > WIDE_B) ? WIDE_A : WIDE_B;
    localparam int WIDE_W     = (WIDE_AB > DIST_LSB + DIST_W) ? WIDE_AB : DIST_LSB + DIST_W;

    localparam int EPS_LEN    = (1 << (2 * FRAC_BITS)) / 10000;
    localparam int SP_CNT_W   = $clog2(SP_BITS + 1);
    localparam int MUL_DIGIT  = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [WIDE_W-1:0]     wide_t;
    typedef logic [SP_BITS:0]             sp_t;
    typedef logic [RADIUS_W-1:0]          radius_t;

    localparam sp_t   SP_ONE   = sp_t'(1) << SP_BITS;
    localparam wide_t EPS_WIDE = wide_t'(EPS_LEN);
    localparam wide_t DEN_EPS  = wide_t'(EPS_LEN) << (2 * FRAC_BITS);

    typedef struct packed {
        coord_t line_start_x;
        coord_t line_start_y;
        coord_t line_start_z;
        coord_t line_end_x;
        coord_t line_end_y;
        coord_t line_end_z;
        coord_t capsule_bottom_x;
        coord_t capsule_bottom_y;
        coord_t capsule_bottom_z;
        coord_t capsule_top_x;
        coord_t capsule_top_y;
        coord_t capsule_top_z;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance_squared;
    } out_item_t;

    // Direction vectors and start offset of one request, as queued.
    typedef struct packed {
        diff_t [2:0] d1;
        diff_t [2:0] d2;
        diff_t [2:0] r;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DOT,
        ST_CLASS,
        ST_AE,
        ST_BB,
        ST_DEN,
        ST_BF,
        ST_CE,
        ST_DIVS0,
        ST_BS,
        ST_TSEL,
        ST_DIVS,
        ST_DIVT,
        ST_DD1,
        ST_DD2,
        ST_DDSQ,
        ST_RAD,
        ST_OUT
    } back_state_t;

    function automatic diff_t coord_diff(coord_t p, coord_t q);
        return diff_t'(q) - diff_t'(p);
    endfunction

endpackage

FILE: sv/scht_front.sv
// Front stage: takes requests and forms the direction and offset vectors.
module scht_front
    import scht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     q_push,
    output entry_t   q_wdata
);

    logic   fv_reg;
    logic   fv_next;
    entry_t ent_reg;
    entry_t ent_next;
    logic   accept;

    assign in_stall = fv_reg && q_full;
    assign q_push   = fv_reg && !q_full;
    assign q_wdata  = ent_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ent_next.d1[0] = coord_diff(in_data.line_start_x, in_data.line_end_x);
        ent_next.d1[1] = coord_diff(in_data.line_start_y, in_data.line_end_y);
        ent_next.d1[2] = coord_diff(in_data.line_start_z, in_data.line_end_z);
        ent_next.d2[0] = coord_diff(in_data.capsule_bottom_x, in_data.capsule_top_x);
        ent_next.d2[1] = coord_diff(in_data.capsule_bottom_y, in_data.capsule_top_y);
        ent_next.d2[2] = coord_diff(in_data.capsule_bottom_z, in_data.capsule_top_z);
        ent_next.r[0]  = coord_diff(in_data.capsule_bottom_x, in_data.line_start_x);
        ent_next.r[1]  = coord_diff(in_data.capsule_bottom_y, in_data.line_start_y);
        ent_next.r[2]  = coord_diff(in_data.capsule_bottom_z, in_data.line_start_z);
    end

    always_comb
    begin
        fv_next = fv_reg;
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (q_push)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

FILE: sv/scht_queue.sv
// Small register queue between the front stage and the back end.
module scht_queue
    import scht_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wdata,
    input  logic   pop,
    output entry_t rdata,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (pop)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

FILE: sv/scht_mul.sv
// Shared signed multiplier, four multiplier bits per cycle, registered product.
module scht_mul
    import scht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t x,
    input  wide_t y,
    output logic  done,
    output wide_t prod
);

    logic [WIDE_W-1:0] mx_reg;
    logic [WIDE_W-1:0] my_reg;
    logic [WIDE_W-1:0] acc_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;
    wide_t             prod_reg;
    logic [WIDE_W-1:0] pp;

    assign done = done_reg;
    assign prod = prod_reg;
    assign pp   = mx_reg * WIDE_W'(my_reg[MUL_DIGIT-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (my_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mx_reg  <= x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
            my_reg  <= y[WIDE_W-1] ? WIDE_W'(-y) : WIDE_W'(y);
            neg_reg <= x[WIDE_W-1] ^ y[WIDE_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (my_reg == '0)
            begin
                prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end
            else
            begin
                acc_reg <= acc_reg + pp;
                mx_reg  <= mx_reg << MUL_DIGIT;
                my_reg  <= my_reg >> MUL_DIGIT;
            end
        end
    end

endmodule

FILE: sv/scht_div.sv
// Clamped divider: num/den limited to [0,1], one quotient bit per cycle.
module scht_div
    import scht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t num,
    input  wide_t den,
    output logic  done,
    output sp_t   quo
);

    logic                busy_reg;
    logic                done_reg;
    logic [SP_CNT_W-1:0] cnt_reg;
    logic [WIDE_W-1:0]   rem_reg;
    logic [WIDE_W-1:0]   den_reg;
    sp_t                 q_reg;
    logic [WIDE_W-1:0]   rem2;

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem2 = rem_reg << 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= WIDE_W'(den);
            rem_reg <= WIDE_W'(num);
            // Clamps are decided before any quotient bit is developed.
            if (num <= wide_t'(0))
            begin
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            else if (num >= den)
            begin
                q_reg   <= SP_ONE;
                cnt_reg <= '0;
            end
            else
            begin
                q_reg   <= '0;
                cnt_reg <= SP_CNT_W'(SP_BITS);
            end
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - SP_CNT_W'(1);
            if (rem2 >= den_reg)
            begin
                rem_reg <= rem2 - den_reg;
                q_reg   <= {q_reg[SP_BITS-1:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2;
                q_reg   <= {q_reg[SP_BITS-1:0], 1'b0};
            end
        end
    end

endmodule

FILE: sv/scht_back.sv
// Back end: sequences dot products, parameter solve, distance and output register.
module scht_back
    import scht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    q_rdata,
    input  logic      q_empty,
    output logic      q_pop,
    input  radius_t   radius,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    back_state_t state_reg;
    back_state_t state_next;
    logic        pend_reg;
    logic        pend_next;
    logic [2:0]  grp_reg;
    logic [2:0]  grp_next;
    logic [1:0]  comp_reg;
    logic [1:0]  comp_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;

    entry_t ent_reg;
    wide_t  a_reg;
    wide_t  e_reg;
    wide_t  b_reg;
    wide_t  c_reg;
    wide_t  f_reg;
    wide_t  tmp_reg;
    wide_t  num_reg;
    wide_t  den_reg;
    wide_t  sum_reg;
    wide_t  lim_reg;
    sp_t    s_reg;
    sp_t    t_reg;

    logic  mul_start;
    wide_t mul_x;
    wide_t mul_y;
    logic  mul_done;
    wide_t mul_prod;
    logic  div_start;
    logic  div_done;
    sp_t   div_quo;

    logic  a_small;
    logic  e_small;
    wide_t e_sh;
    logic  out_free;
    logic  dot_last;
    logic  sat;
    wide_t d1_w;
    wide_t d2_w;
    wide_t r_w;

    scht_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    scht_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign a_small   = (a_reg <= EPS_WIDE);
    assign e_small   = (e_reg <= EPS_WIDE);
    assign e_sh      = e_reg <<< SP_BITS;
    assign out_free  = !out_valid_reg || !out_stall;
    assign dot_last  = (grp_reg == 3'd4) && (comp_reg == 2'd2);
    assign sat       = |sum_reg[WIDE_W-1:DIST_LSB+DIST_W];
    assign d1_w      = wide_t'($signed(ent_reg.d1[comp_reg]));
    assign d2_w      = wide_t'($signed(ent_reg.d2[comp_reg]));
    assign r_w       = wide_t'($signed(ent_reg.r[comp_reg]));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next state, issue flag and index counters.
    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (mul_start || div_start)
        begin
            pend_next = 1'b1;
        end
        else if (mul_done || div_done)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_DOT;
                    grp_next   = '0;
                    comp_next  = '0;
                end
            end
            ST_DOT:
            begin
                if (mul_done)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        comp_next = '0;
                        grp_next  = grp_reg + 3'd1;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                    if (dot_last)
                    begin
                        state_next = ST_CLASS;
                    end
                end
            end
            ST_CLASS:
            begin
                if (a_small && e_small)
                begin
                    state_next = ST_DD1;
                end
                else if (a_small)
                begin
                    state_next = ST_DIVT;
                end
                else if (e_small)
                begin
                    state_next = ST_DIVS;
                end
                else
                begin
                    state_next = ST_AE;
                end
            end
            ST_AE:    if (mul_done) state_next = ST_BB;
            ST_BB:    if (mul_done) state_next = ST_DEN;
            ST_DEN:   state_next = (den_reg > DEN_EPS) ? ST_BF : ST_BS;
            ST_BF:    if (mul_done) state_next = ST_CE;
            ST_CE:    if (mul_done) state_next = ST_DIVS0;
            ST_DIVS0: if (div_done) state_next = ST_BS;
            ST_BS:    if (mul_done) state_next = ST_TSEL;
            ST_TSEL:
            begin
                if ((num_reg < wide_t'(0)) || (num_reg > e_sh))
                begin
                    state_next = ST_DIVS;
                end
                else
                begin
                    state_next = ST_DIVT;
                end
            end
            ST_DIVS:  if (div_done) state_next = ST_DD1;
            ST_DIVT:  if (div_done) state_next = ST_DD1;
            ST_DD1:   if (mul_done) state_next = ST_DD2;
            ST_DD2:   if (mul_done) state_next = ST_DDSQ;
            ST_DDSQ:
            begin
                if (mul_done)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_RAD;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DD1;
                    end
                end
            end
            ST_RAD:   if (mul_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Unit operands and issue strobes for the current step.
    always_comb
    begin
        mul_x     = '0;
        mul_y     = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        q_pop     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_DOT:
            begin
                case (grp_reg)
                    3'd0:    begin mul_x = d1_w; mul_y = d1_w; end
                    3'd1:    begin mul_x = d2_w; mul_y = d2_w; end
                    3'd2:    begin mul_x = d1_w; mul_y = d2_w; end
                    3'd3:    begin mul_x = d1_w; mul_y = r_w;  end
                    default: begin mul_x = d2_w; mul_y = r_w;  end
                endcase
                mul_start = !pend_reg;
            end
            ST_AE:   begin mul_x = a_reg;   mul_y = e_reg;   mul_start = !pend_reg; end
            ST_BB:   begin mul_x = b_reg;   mul_y = b_reg;   mul_start = !pend_reg; end
            ST_BF:   begin mul_x = b_reg;   mul_y = f_reg;   mul_start = !pend_reg; end
            ST_CE:   begin mul_x = c_reg;   mul_y = e_reg;   mul_start = !pend_reg; end
            ST_BS:
            begin
                mul_x     = b_reg;
                mul_y     = wide_t'(s_reg);
                mul_start = !pend_reg;
            end
            ST_DD1:
            begin
                mul_x     = d1_w;
                mul_y     = wide_t'(s_reg);
                mul_start = !pend_reg;
            end
            ST_DD2:
            begin
                mul_x     = d2_w;
                mul_y     = wide_t'(t_reg);
                mul_start = !pend_reg;
            end
            ST_DDSQ: begin mul_x = tmp_reg; mul_y = tmp_reg; mul_start = !pend_reg; end
            ST_RAD:
            begin
                mul_x     = wide_t'(radius);
                mul_y     = wide_t'(radius);
                mul_start = !pend_reg;
            end
            ST_DIVS0, ST_DIVS, ST_DIVT:
            begin
                div_start = !pend_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            grp_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            grp_reg       <= grp_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    ent_reg <= q_rdata;
                    a_reg   <= '0;
                    e_reg   <= '0;
                    b_reg   <= '0;
                    c_reg   <= '0;
                    f_reg   <= '0;
                    sum_reg <= '0;
                    s_reg   <= '0;
                    t_reg   <= '0;
                end
            end
            ST_DOT:
            begin
                if (mul_done)
                begin
                    case (grp_reg)
                        3'd0:    a_reg <= a_reg + mul_prod;
                        3'd1:    e_reg <= e_reg + mul_prod;
                        3'd2:    b_reg <= b_reg + mul_prod;
                        3'd3:    c_reg <= c_reg + mul_prod;
                        default: f_reg <= f_reg + mul_prod;
                    endcase
                end
            end
            ST_CLASS:
            begin
                if (a_small && !e_small)
                begin
                    num_reg <= f_reg;
                    den_reg <= e_reg;
                end
                else if (!a_small && e_small)
                begin
                    num_reg <= -c_reg;
                    den_reg <= a_reg;
                end
            end
            ST_AE:    if (mul_done) tmp_reg <= mul_prod;
            ST_BB:    if (mul_done) den_reg <= tmp_reg - mul_prod;
            ST_BF:    if (mul_done) tmp_reg <= mul_prod;
            ST_CE:    if (mul_done) num_reg <= tmp_reg - mul_prod;
            ST_DIVS0: if (div_done) s_reg <= div_quo;
            ST_BS:    if (mul_done) num_reg <= mul_prod + (f_reg <<< SP_BITS);
            ST_TSEL:
            begin
                // The t clamps force s to be solved again against the first segment.
                if (num_reg < wide_t'(0))
                begin
                    t_reg   <= '0;
                    num_reg <= -c_reg;
                    den_reg <= a_reg;
                end
                else if (num_reg > e_sh)
                begin
                    t_reg   <= SP_ONE;
                    num_reg <= b_reg - c_reg;
                    den_reg <= a_reg;
                end
                else
                begin
                    den_reg <= e_sh;
                end
            end
            ST_DIVS:  if (div_done) s_reg <= div_quo;
            ST_DIVT:  if (div_done) t_reg <= div_quo;
            ST_DD1:   if (mul_done) tmp_reg <= (r_w <<< SP_BITS) + mul_prod;
            ST_DD2:   if (mul_done) tmp_reg <= tmp_reg - mul_prod;
            ST_DDSQ:  if (mul_done) sum_reg <= sum_reg + mul_prod;
            ST_RAD:   if (mul_done) lim_reg <= mul_prod <<< DIST_LSB;
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg.hit              <= (sum_reg <= lim_reg);
                    out_data_reg.distance_squared <= sat ? '1
                                                         : sum_reg[DIST_LSB +: DIST_W];
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

endmodule

FILE: sv/segment_capsule_hit_test.sv
// Throughput: one request per back-end pass; the shared radix-16 multiplier (up to 30
// products per pass) and the bit-serial divider (at most two quotients) set it.
// The front stage and queue take up to five requests back to back while the back end works.
// Reset is asynchronous and active low; it empties the queue and sets the radius to 1.0.
module segment_capsule_hit_test
    import scht_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  radius_t   cfg_data
);

    radius_t radius_reg;
    entry_t  q_wdata;
    entry_t  q_rdata;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= radius_t'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    scht_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    scht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    scht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .radius    (radius_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // A hit can never report a distance above the radius squared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |->
        (out_data.distance_squared <= (DIST_W'(radius_reg) * DIST_W'(radius_reg))))
        else $error("hit reported with distance above radius squared");

    // The back end only takes work from a queue that holds some.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // The front stage never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> !(q_push && $past(q_full)) || q_full)
        else $error("queue overflow");
`endif

endmodule
